### src/assert_macros.svh
// Assertion macros for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define CHK_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/gdir_pkg.sv
// Types and constants for the grasp direction pipeline.
package gdir_pkg;

  typedef logic signed [15:0] q14_t;

  localparam q14_t ONE_Q14     = 16'sd16384;
  localparam int   NORM_MSB    = 29;
  localparam int   NORM_W      = 30;
  localparam int   SQ_W        = 62;
  localparam int   ROOT_W      = 31;
  localparam int   SQRT_STEPS  = 31;
  localparam int   DIV_STEPS   = 15;
  localparam int   UNIT_LAT    = 7 + SQRT_STEPS + DIV_STEPS + 1;

  typedef enum logic [1:0] {
    ST_NORMAL = 2'd0,
    ST_SAME   = 2'd1,
    ST_MID    = 2'd2,
    ST_ZERO   = 2'd3
  } stat_t;

  typedef struct packed {
    logic vld;
    logic ab;
    logic eq;
    logic okf;
    q14_t fx;
    q14_t fy;
    q14_t fz;
    q14_t bx;
    q14_t by;
    q14_t bz;
  } sbn_t;

  typedef struct packed {
    logic vld;
    logic ab;
    logic eq;
    logic nok;
    logic okf;
    q14_t fx;
    q14_t fy;
    q14_t fz;
  } sbg_t;

endpackage

### src/gdir_unit.sv
// Pipelined fixed-point 3D vector normalizer to Q1.14.
module gdir_unit #(
  parameter int IW = 33,
  parameter int SW = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic signed [IW-1:0] in_x,
  input  logic signed [IW-1:0] in_y,
  input  logic signed [IW-1:0] in_z,
  input  logic [SW-1:0]        in_sb,
  output gdir_pkg::q14_t       out_x,
  output gdir_pkg::q14_t       out_y,
  output gdir_pkg::q14_t       out_z,
  output logic                 out_ok,
  output logic [SW-1:0]        out_sb
);
  import gdir_pkg::*;

  localparam int PW   = $clog2(IW);
  localparam int MW   = (IW > NORM_W) ? IW : NORM_W;
  localparam int LAT  = UNIT_LAT;
  localparam int AUXN = LAT - 4;
  localparam int NUMW = NORM_W + 16;

  logic [IW-1:0]     abs_v [3];
  logic [IW-1:0]     m1_r [3];
  logic [IW-1:0]     m2_r [3];
  logic [IW-1:0]     m3_r [3];
  logic [2:0]        ng1_r, ng2_r, ng3_r;
  logic [IW-1:0]     mx2_r;
  logic [PW-1:0]     pos_v, pos3_r;
  logic              nz3_r;
  logic [NORM_W-1:0] n4_r [3];
  logic [NORM_W-1:0] n5_r [3];
  logic [NORM_W-1:0] n6_r [3];
  logic [2*NORM_W-1:0] sq5_r [3];
  logic [SQ_W-1:0]   s6_r;
  logic [3:0]        aux_r [AUXN];
  logic [SW-1:0]     sb_r [LAT];

  logic [SQ_W-1:0]   sx_in [SQRT_STEPS];
  logic [SQ_W-1:0]   sr_in [SQRT_STEPS];
  logic [SQ_W-1:0]   sx_r [SQRT_STEPS];
  logic [SQ_W-1:0]   sr_r [SQRT_STEPS];
  logic [NORM_W-1:0] sm_in [SQRT_STEPS][3];
  logic [NORM_W-1:0] sm_r [SQRT_STEPS][3];

  logic [NUMW-1:0]   nu_r [3];
  logic [ROOT_W-1:0] rr_r;

  logic [NUMW-1:0]   dr_in [DIV_STEPS][3];
  logic [DIV_STEPS-1:0] dq_in [DIV_STEPS][3];
  logic [ROOT_W-1:0] dd_in [DIV_STEPS];
  logic [NUMW-1:0]   dr_r [DIV_STEPS][3];
  logic [DIV_STEPS-1:0] dq_r [DIV_STEPS][3];
  logic [ROOT_W-1:0] dd_r [DIV_STEPS];

  q14_t              o_r [3];
  logic              ok_r;

  assign abs_v[0] = in_x[IW-1] ? ($unsigned(~in_x) + 1'b1) : $unsigned(in_x);
  assign abs_v[1] = in_y[IW-1] ? ($unsigned(~in_y) + 1'b1) : $unsigned(in_y);
  assign abs_v[2] = in_z[IW-1] ? ($unsigned(~in_z) + 1'b1) : $unsigned(in_z);

  always_comb begin
    pos_v = '0;
    for (int i = 0; i < IW; i++) begin
      if (mx2_r[i]) begin
        pos_v = PW'(i);
      end
    end
  end

  // sideband and valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LAT; k++) begin
        sb_r[k] <= '0;
      end
    end else if (en) begin
      sb_r[0] <= in_sb;
      for (int k = 1; k < LAT; k++) begin
        sb_r[k] <= sb_r[k-1];
      end
    end
  end

  // magnitude, max, leading one, scaling, squares
  always_ff @(posedge clk) begin
    if (en) begin
      m1_r  <= abs_v;
      ng1_r <= {in_z[IW-1], in_y[IW-1], in_x[IW-1]};
      m2_r  <= m1_r;
      ng2_r <= ng1_r;
      if (m1_r[0] >= m1_r[1] && m1_r[0] >= m1_r[2]) begin
        mx2_r <= m1_r[0];
      end else if (m1_r[1] >= m1_r[2]) begin
        mx2_r <= m1_r[1];
      end else begin
        mx2_r <= m1_r[2];
      end
      m3_r   <= m2_r;
      ng3_r  <= ng2_r;
      pos3_r <= pos_v;
      nz3_r  <= |mx2_r;
      for (int i = 0; i < 3; i++) begin
        if (int'(pos3_r) >= NORM_MSB) begin
          n4_r[i] <= NORM_W'(MW'(m3_r[i]) >> (int'(pos3_r) - NORM_MSB));
        end else begin
          n4_r[i] <= NORM_W'(MW'(m3_r[i]) << (NORM_MSB - int'(pos3_r)));
        end
        sq5_r[i] <= n4_r[i] * n4_r[i];
      end
      n5_r <= n4_r;
      n6_r <= n5_r;
      s6_r <= SQ_W'(sq5_r[0]) + SQ_W'(sq5_r[1]) + SQ_W'(sq5_r[2]);
      aux_r[0] <= {nz3_r, ng3_r};
      for (int k = 1; k < AUXN; k++) begin
        aux_r[k] <= aux_r[k-1];
      end
    end
  end

  // integer square root, one result bit per stage
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQRT_STEPS - 1 - k));
    logic [SQ_W:0] trial;
    if (k == 0) begin : g_first
      assign sx_in[k] = s6_r;
      assign sr_in[k] = '0;
      assign sm_in[k] = n6_r;
    end else begin : g_next
      assign sx_in[k] = sx_r[k-1];
      assign sr_in[k] = sr_r[k-1];
      assign sm_in[k] = sm_r[k-1];
    end
    assign trial = {1'b0, sr_in[k]} + {1'b0, BIT};
    always_ff @(posedge clk) begin
      if (en) begin
        sm_r[k] <= sm_in[k];
        if ({1'b0, sx_in[k]} >= trial) begin
          sx_r[k] <= sx_in[k] - trial[SQ_W-1:0];
          sr_r[k] <= (sr_in[k] >> 1) + BIT;
        end else begin
          sx_r[k] <= sx_in[k];
          sr_r[k] <= sr_in[k] >> 1;
        end
      end
    end
  end

  // numerator with half-divisor rounding
  always_ff @(posedge clk) begin
    if (en) begin
      rr_r <= sr_r[SQRT_STEPS-1][ROOT_W-1:0];
      for (int i = 0; i < 3; i++) begin
        nu_r[i] <= {2'b00, sm_r[SQRT_STEPS-1][i], 14'd0}
                 + NUMW'(sr_r[SQRT_STEPS-1][ROOT_W-1:1]);
      end
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar t = 0; t < DIV_STEPS; t++) begin : g_div
    localparam int J = DIV_STEPS - 1 - t;
    logic [NUMW-1:0] dv;
    if (t == 0) begin : g_first
      assign dd_in[t] = rr_r;
      for (genvar i = 0; i < 3; i++) begin : g_l
        assign dr_in[t][i] = nu_r[i];
        assign dq_in[t][i] = '0;
      end
    end else begin : g_next
      assign dd_in[t] = dd_r[t-1];
      for (genvar i = 0; i < 3; i++) begin : g_l
        assign dr_in[t][i] = dr_r[t-1][i];
        assign dq_in[t][i] = dq_r[t-1][i];
      end
    end
    assign dv = NUMW'(dd_in[t]) << J;
    always_ff @(posedge clk) begin
      if (en) begin
        dd_r[t] <= dd_in[t];
        for (int i = 0; i < 3; i++) begin
          if (dr_in[t][i] >= dv) begin
            dr_r[t][i] <= dr_in[t][i] - dv;
            dq_r[t][i] <= dq_in[t][i] | (DIV_STEPS'(1) << J);
          end else begin
            dr_r[t][i] <= dr_in[t][i];
            dq_r[t][i] <= dq_in[t][i];
          end
        end
      end
    end
  end

  // sign and zero mask
  always_ff @(posedge clk) begin
    if (en) begin
      ok_r <= aux_r[AUXN-1][3];
      for (int i = 0; i < 3; i++) begin
        if (!aux_r[AUXN-1][3]) begin
          o_r[i] <= '0;
        end else if (aux_r[AUXN-1][i]) begin
          o_r[i] <= -$signed({1'b0, dq_r[DIV_STEPS-1][i]});
        end else begin
          o_r[i] <= $signed({1'b0, dq_r[DIV_STEPS-1][i]});
        end
      end
    end
  end

  assign out_x  = o_r[0];
  assign out_y  = o_r[1];
  assign out_z  = o_r[2];
  assign out_ok = ok_r;
  assign out_sb = sb_r[LAT-1];

endmodule

### src/grasp_direction_from_three_points.sv
// Grasp direction pipeline. Throughput one item per cycle while the output is not stalled;
// three normalizer pipelines lie in series between accept and out_valid,
// each with a 31-stage square root and a 15-stage divider.
// A stalled output freezes the whole pipeline; in_stall follows it.
// Synchronous active-low reset clears all valid bits; no clearing pass.
module grasp_direction_from_three_points #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_top_x,
  input  logic signed [COORD_WIDTH-1:0] in_top_y,
  input  logic signed [COORD_WIDTH-1:0] in_top_z,
  input  logic signed [COORD_WIDTH-1:0] in_mid_x,
  input  logic signed [COORD_WIDTH-1:0] in_mid_y,
  input  logic signed [COORD_WIDTH-1:0] in_mid_z,
  input  logic signed [COORD_WIDTH-1:0] in_btm_x,
  input  logic signed [COORD_WIDTH-1:0] in_btm_y,
  input  logic signed [COORD_WIDTH-1:0] in_btm_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output gdir_pkg::q14_t                out_dir_x,
  output gdir_pkg::q14_t                out_dir_y,
  output gdir_pkg::q14_t                out_dir_z,
  output logic [1:0]                    out_status
);
  import gdir_pkg::*;
  `include "assert_macros.svh"

  localparam int W  = COORD_WIDTH;
  localparam int CW = 31;
  localparam int PWD = 30;

  function automatic logic signed [PWD-1:0] qmul(q14_t a, q14_t b);
    logic signed [31:0] p;
    p = 32'(a) * 32'(b);
    return p[PWD-1:0];
  endfunction

  logic en;
  logic v0_r;
  logic signed [W:0]   va_r [3];
  logic signed [W:0]   vb_r [3];
  logic signed [W+1:0] vf_r [3];

  q14_t ua [3], ub [3], uf [3], un [3], ug [3];
  logic oka, okb, okf, nok, gok;
  logic sba, sbb, sbf;

  logic        c1v_r, c1ab_r, c1eq_r, c1okf_r;
  q14_t        c1f_r [3], c1b_r [3];
  logic signed [PWD-1:0] c1p_r [6];
  sbn_t        sbn_in, sbn_out;
  logic signed [CW-1:0] cx_r, cy_r, cz_r;
  logic [$bits(sbn_t)-1:0] sbn_vec;

  logic signed [PWD-1:0] c3p_r [6];
  sbg_t        c3_r, sbg_in, sbg_out;
  logic signed [CW-1:0] gx_r, gy_r, gz_r;
  logic [$bits(sbg_t)-1:0] sbg_vec;

  logic        out_valid_r;
  q14_t        dx_nxt, dy_nxt, dz_nxt, dx_r, dy_r, dz_r;
  stat_t       st_nxt, st_r;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  // differences and fallback vector (twice midpoint minus twice middle)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      va_r[0] <= (W+1)'(in_mid_x) - (W+1)'(in_top_x);
      va_r[1] <= (W+1)'(in_mid_y) - (W+1)'(in_top_y);
      va_r[2] <= (W+1)'(in_mid_z) - (W+1)'(in_top_z);
      vb_r[0] <= (W+1)'(in_btm_x) - (W+1)'(in_top_x);
      vb_r[1] <= (W+1)'(in_btm_y) - (W+1)'(in_top_y);
      vb_r[2] <= (W+1)'(in_btm_z) - (W+1)'(in_top_z);
      vf_r[0] <= (W+2)'(in_top_x) + (W+2)'(in_btm_x) - ((W+2)'(in_mid_x) <<< 1);
      vf_r[1] <= (W+2)'(in_top_y) + (W+2)'(in_btm_y) - ((W+2)'(in_mid_y) <<< 1);
      vf_r[2] <= (W+2)'(in_top_z) + (W+2)'(in_btm_z) - ((W+2)'(in_mid_z) <<< 1);
    end
  end

  gdir_unit #(.IW(W+1), .SW(1)) u_a (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_x(va_r[0]), .in_y(va_r[1]), .in_z(va_r[2]), .in_sb(v0_r),
    .out_x(ua[0]), .out_y(ua[1]), .out_z(ua[2]), .out_ok(oka), .out_sb(sba)
  );

  gdir_unit #(.IW(W+1), .SW(1)) u_b (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_x(vb_r[0]), .in_y(vb_r[1]), .in_z(vb_r[2]), .in_sb(v0_r),
    .out_x(ub[0]), .out_y(ub[1]), .out_z(ub[2]), .out_ok(okb), .out_sb(sbb)
  );

  gdir_unit #(.IW(W+2), .SW(1)) u_f (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_x(vf_r[0]), .in_y(vf_r[1]), .in_z(vf_r[2]), .in_sb(v0_r),
    .out_x(uf[0]), .out_y(uf[1]), .out_z(uf[2]), .out_ok(okf), .out_sb(sbf)
  );

  // a x b: products, then differences
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1v_r <= 1'b0;
    end else if (en) begin
      c1v_r <= sba;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1ab_r   <= oka && okb;
      c1eq_r   <= (ua[0] == ub[0]) && (ua[1] == ub[1]) && (ua[2] == ub[2]);
      c1okf_r  <= okf;
      c1f_r    <= uf;
      c1b_r    <= ub;
      c1p_r[0] <= qmul(ua[1], ub[2]);
      c1p_r[1] <= qmul(ua[2], ub[1]);
      c1p_r[2] <= qmul(ua[2], ub[0]);
      c1p_r[3] <= qmul(ua[0], ub[2]);
      c1p_r[4] <= qmul(ua[0], ub[1]);
      c1p_r[5] <= qmul(ua[1], ub[0]);
      cx_r <= CW'(c1p_r[0]) - CW'(c1p_r[1]);
      cy_r <= CW'(c1p_r[2]) - CW'(c1p_r[3]);
      cz_r <= CW'(c1p_r[4]) - CW'(c1p_r[5]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sbn_in <= '0;
    end else if (en) begin
      sbn_in <= '{vld: c1v_r, ab: c1ab_r, eq: c1eq_r, okf: c1okf_r,
                  fx: c1f_r[0], fy: c1f_r[1], fz: c1f_r[2],
                  bx: c1b_r[0], by: c1b_r[1], bz: c1b_r[2]};
    end
  end

  gdir_unit #(.IW(CW), .SW($bits(sbn_t))) u_n (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_x(cx_r), .in_y(cy_r), .in_z(cz_r), .in_sb(sbn_in),
    .out_x(un[0]), .out_y(un[1]), .out_z(un[2]), .out_ok(nok), .out_sb(sbn_vec)
  );

  assign sbn_out = sbn_t'(sbn_vec);

  // n x b: products, then differences
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c3_r   <= '0;
      sbg_in <= '0;
    end else if (en) begin
      c3_r   <= '{vld: sbn_out.vld, ab: sbn_out.ab, eq: sbn_out.eq, nok: nok,
                  okf: sbn_out.okf, fx: sbn_out.fx, fy: sbn_out.fy, fz: sbn_out.fz};
      sbg_in <= c3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c3p_r[0] <= qmul(un[1], sbn_out.bz);
      c3p_r[1] <= qmul(un[2], sbn_out.by);
      c3p_r[2] <= qmul(un[2], sbn_out.bx);
      c3p_r[3] <= qmul(un[0], sbn_out.bz);
      c3p_r[4] <= qmul(un[0], sbn_out.by);
      c3p_r[5] <= qmul(un[1], sbn_out.bx);
      gx_r <= CW'(c3p_r[0]) - CW'(c3p_r[1]);
      gy_r <= CW'(c3p_r[2]) - CW'(c3p_r[3]);
      gz_r <= CW'(c3p_r[4]) - CW'(c3p_r[5]);
    end
  end

  gdir_unit #(.IW(CW), .SW($bits(sbg_t))) u_g (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_x(gx_r), .in_y(gy_r), .in_z(gz_r), .in_sb(sbg_in),
    .out_x(ug[0]), .out_y(ug[1]), .out_z(ug[2]), .out_ok(gok), .out_sb(sbg_vec)
  );

  assign sbg_out = sbg_t'(sbg_vec);

  // result select
  always_comb begin
    priority if (sbg_out.ab && sbg_out.eq) begin
      dx_nxt = ONE_Q14;
      dy_nxt = '0;
      dz_nxt = '0;
      st_nxt = ST_SAME;
    end else if (sbg_out.ab && sbg_out.nok && gok) begin
      dx_nxt = ug[0][15] ? -ug[0] : ug[0];
      dy_nxt = ug[0][15] ? -ug[1] : ug[1];
      dz_nxt = ug[0][15] ? -ug[2] : ug[2];
      st_nxt = ST_NORMAL;
    end else if (sbg_out.okf) begin
      dx_nxt = sbg_out.fx;
      dy_nxt = sbg_out.fy;
      dz_nxt = sbg_out.fz;
      st_nxt = ST_MID;
    end else begin
      dx_nxt = '0;
      dy_nxt = '0;
      dz_nxt = '0;
      st_nxt = ST_ZERO;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= sbg_out.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r <= dx_nxt;
      dy_r <= dy_nxt;
      dz_r <= dz_nxt;
      st_r <= st_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_dir_x  = dx_r;
  assign out_dir_y  = dy_r;
  assign out_dir_z  = dz_r;
  assign out_status = st_r;

  `CHK_IMPL(a_lanes_aligned, 1'b1, (sba == sbb) && (sba == sbf), "normalizer lanes out of step")
  `CHK_IMPL(a_same_dir, out_valid_r && st_r == ST_SAME,
            dx_r == ONE_Q14 && dy_r == 16'sd0 && dz_r == 16'sd0, "same-direction result not +x")
  `CHK_IMPL(a_zero_dir, out_valid_r && st_r == ST_ZERO,
            dx_r == 16'sd0 && dy_r == 16'sd0 && dz_r == 16'sd0, "degenerate result not zero")
  `CHK_NEXT(a_stall_hold, out_valid_r && out_stall, out_valid_r && $stable(st_r),
            "stalled item lost")

endmodule
